// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hrhc_pkg.sv
// ---------------------------------------------------------------------------
// hrhc_pkg
// Types, character constants and per-byte update functions of the checker.
// ---------------------------------------------------------------------------
package hrhc_pkg;

    typedef enum logic [1:0] {
        PH_REQUEST = 2'd0,
        PH_HEADER  = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        V_VALID      = 2'd0,
        V_INVALID    = 2'd1,
        V_INCOMPLETE = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_BLANK = 2'd1,
        CLS_COLON = 2'd2,
        CLS_CR    = 2'd3
    } cls_t;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned VER_LEN = 8;

    localparam logic [3:0] POS_FULL     = 4'd8;
    localparam logic [3:0] POS_TOO_LONG = 4'd9;
    localparam logic [3:0] POS_ACCEPTED = 4'd15;
    localparam logic [1:0] TOK_LAST     = 2'd3;
    localparam logic [1:0] LEN_SAT      = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        phase_t     phase;
        verdict_t   held;
        logic       nonempty;
        logic [1:0] tok_cnt;
        logic       in_tok;
        logic [3:0] ver_pos;
        logic [1:0] ver_match;   // bit0 still HTTP/1.1, bit1 still HTTP/1.0
        logic [1:0] line_len;
        cls_t       first_cls;
        logic       colon_seen;
        logic       hdr_seen;
    } st_t;

    localparam st_t ST_RESET = '{
        phase:      PH_REQUEST,
        held:       V_VALID,
        nonempty:   1'b0,
        tok_cnt:    2'd0,
        in_tok:     1'b0,
        ver_pos:    4'd0,
        ver_match:  2'b11,
        line_len:   2'd0,
        first_cls:  CLS_OTHER,
        colon_seen: 1'b0,
        hdr_seen:   1'b0
    };

    // Expected version character; only the last one differs between 1.1 and 1.0.
    function automatic logic [7:0] ver_char(input logic [2:0] pos, input logic one);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h48;  // H
            3'd1:    c = 8'h54;  // T
            3'd2:    c = 8'h54;  // T
            3'd3:    c = 8'h50;  // P
            3'd4:    c = 8'h2F;  // /
            3'd5:    c = 8'h31;  // 1
            3'd6:    c = 8'h2E;  // .
            3'd7:    c = one ? 8'h31 : 8'h30;
            default: c = 8'h48;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic st_t decide(input st_t s, input verdict_t v);
        st_t r;
        r = s;
        r.phase = PH_DONE;
        r.held  = v;
        return r;
    endfunction

    function automatic st_t clear_line(input st_t s);
        st_t r;
        r = s;
        r.line_len   = 2'd0;
        r.first_cls  = CLS_OTHER;
        r.colon_seen = 1'b0;
        return r;
    endfunction

    function automatic st_t finish_version(input st_t s);
        st_t r;
        r = s;
        if ((r.ver_pos == POS_FULL) && (r.ver_match != 2'b00)) begin
            r.ver_pos = POS_ACCEPTED;
        end else begin
            r = decide(r, V_INVALID);
        end
        return r;
    endfunction

    function automatic st_t end_request_line(input st_t s);
        st_t r;
        r = s;
        if (r.in_tok && (r.tok_cnt == TOK_LAST) && (r.ver_pos != POS_ACCEPTED)) begin
            r = finish_version(r);
        end
        r.in_tok = 1'b0;
        if (r.phase == PH_REQUEST) begin
            if ((r.tok_cnt == TOK_LAST) && (r.ver_pos == POS_ACCEPTED)) begin
                r.phase = PH_HEADER;
                r = clear_line(r);
            end else begin
                r = decide(r, V_INVALID);
            end
        end
        return r;
    endfunction

    function automatic st_t request_byte(input st_t s, input logic [7:0] b);
        st_t r;
        r = s;
        if (b == CH_LF) begin
            r = end_request_line(r);
        end else if (is_space(b)) begin
            if (r.in_tok) begin
                r.in_tok = 1'b0;
                if ((r.tok_cnt == TOK_LAST) && (r.ver_pos != POS_ACCEPTED)) begin
                    r = finish_version(r);
                end
            end
        end else begin
            if (!r.in_tok) begin
                r.in_tok = 1'b1;
                if (r.tok_cnt != TOK_LAST) begin
                    r.tok_cnt = r.tok_cnt + 2'd1;
                    if (r.tok_cnt == TOK_LAST) begin
                        r.ver_pos   = 4'd0;
                        r.ver_match = 2'b11;
                    end
                end
            end
            if ((r.tok_cnt == TOK_LAST) && (r.ver_pos <= POS_FULL)) begin
                if (r.ver_pos < POS_FULL) begin
                    if (b != ver_char(r.ver_pos[2:0], 1'b1)) begin
                        r.ver_match[0] = 1'b0;
                    end
                    if (b != ver_char(r.ver_pos[2:0], 1'b0)) begin
                        r.ver_match[1] = 1'b0;
                    end
                    r.ver_pos = r.ver_pos + 4'd1;
                end else begin
                    r.ver_pos = POS_TOO_LONG;
                end
            end
        end
        return r;
    endfunction

    function automatic st_t end_header_line(input st_t s);
        st_t  r;
        logic empty;
        r = s;
        empty = (r.line_len == 2'd0) || ((r.line_len == 2'd1) && (r.first_cls == CLS_CR));
        if (empty) begin
            r = decide(r, V_VALID);
        end else if (r.first_cls == CLS_BLANK) begin
            if (!r.hdr_seen) begin
                r = decide(r, V_INVALID);
            end
        end else if ((r.first_cls == CLS_COLON) || !r.colon_seen) begin
            r = decide(r, V_INVALID);
        end else begin
            r.hdr_seen = 1'b1;
        end
        r = clear_line(r);
        return r;
    endfunction

    function automatic st_t header_byte(input st_t s, input logic [7:0] b);
        st_t r;
        r = s;
        if (b == CH_LF) begin
            r = end_header_line(r);
        end else begin
            if (r.line_len == 2'd0) begin
                if ((b == CH_SP) || (b == CH_TAB)) begin
                    r.first_cls = CLS_BLANK;
                end else if (b == CH_COLON) begin
                    r.first_cls = CLS_COLON;
                end else if (b == CH_CR) begin
                    r.first_cls = CLS_CR;
                end else begin
                    r.first_cls = CLS_OTHER;
                end
            end else if (b == CH_COLON) begin
                r.colon_seen = 1'b1;
            end
            if (r.line_len != LEN_SAT) begin
                r.line_len = r.line_len + 2'd1;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/http_request_header_checker.sv
// HTTP request header checker. Requests carry one byte of message text each
// (tdata), a byte-present flag (tuser, low for a bare end mark) and tlast on the
// final request of a message. At each tlast the block emits one verdict:
// 0 valid (an empty header line was reached), 1 invalid (request line without
// three tokens, third token not HTTP/1.0 or HTTP/1.1, or a malformed header
// line), 2 incomplete (empty message, or the end came before the empty line).
// Throughput is one request per cycle unless stalled: a request is held in
// an input register while the parser state and the verdict register are
// updated by a single combinational pass. The only backpressure comes from
// a verdict waiting in the output register while another tlast request
// wants to leave.
// ---------------------------------------------------------------------------
// http_request_header_checker
// Byte-serial HTTP request line and header syntax checker, one verdict per
// message.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module http_request_header_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hrhc_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]                    s_tuser,   // [0] byte_valid
    input  logic                          s_tlast,   // end_of_message
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata    // [1:0] verdict, [7:2] zero
);
    import hrhc_pkg::*;

    // Input register stage
    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_byte_reg,  in_byte_next;
    logic              in_has_reg,   in_has_next;
    logic              in_last_reg,  in_last_next;

    // Parser state
    st_t st_reg, st_next;

    // Result register
    logic     m_tvalid_reg, m_tvalid_next;
    verdict_t m_verdict_reg, m_verdict_next;

    logic     out_free;
    logic     adv;
    verdict_t verdict;

    // A request leaves the input register unless it carries a verdict that
    // has nowhere to go.
    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || adv;

    // Input register: load on accept, drop after advancing.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_has_next   = in_has_reg;
        in_last_next  = in_last_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
            in_has_next   = s_tuser[0];
            in_last_next  = s_tlast;
        end
    end

    // Next-state pass: byte update, then end-of-message wrap-up.
    always_comb begin
        st_t s;
        s       = st_reg;
        verdict = V_INCOMPLETE;
        if (in_has_reg) begin
            s.nonempty = 1'b1;
            case (s.phase)
                PH_REQUEST: s = request_byte(s, in_byte_reg);
                PH_HEADER:  s = header_byte(s, in_byte_reg);
                default:    s = s;
            endcase
        end
        if (in_last_reg) begin
            if (s.phase == PH_REQUEST) begin
                if (s.nonempty) begin
                    s = end_request_line(s);
                end else begin
                    s = decide(s, V_INCOMPLETE);
                end
            end else if ((s.phase == PH_HEADER) && (s.line_len != 2'd0)) begin
                s = end_header_line(s);
            end
            verdict = (s.phase == PH_DONE) ? s.held : V_INCOMPLETE;
            s       = ST_RESET;
        end
        st_next = adv ? s : st_reg;
    end

    // Output register: hold while stalled, load a verdict on a tlast request.
    always_comb begin
        m_tvalid_next  = m_tvalid_reg;
        m_verdict_next = m_verdict_reg;
        if (out_free) begin
            m_tvalid_next  = adv && in_last_reg;
            m_verdict_next = verdict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            st_reg       <= ST_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            st_reg       <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        in_has_reg    <= in_has_next;
        in_last_reg   <= in_last_next;
        m_verdict_reg <= m_verdict_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_verdict_reg};

    `ASSERT_NEXT(a_end_gives_verdict, aclk, aresetn, adv && in_last_reg,
        m_tvalid_reg && (st_reg == ST_RESET), "end of message did not yield verdict and reset")
    `ASSERT_IMPLIES(a_header_needs_version, aclk, aresetn, st_reg.phase == PH_HEADER,
        (st_reg.tok_cnt == TOK_LAST) && (st_reg.ver_pos == POS_ACCEPTED),
        "header phase without accepted request line")
    `ASSERT_IMPLIES(a_done_needs_byte, aclk, aresetn, st_reg.phase == PH_DONE,
        st_reg.nonempty, "decision held for a message with no byte")
    `ASSERT_NEXT(a_stalled_input_held, aclk, aresetn, in_valid_reg && !adv,
        in_valid_reg && in_last_reg, "stalled request lost from input register")

endmodule

// File: sim/tb_http_request_header_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_request_header_checker
// Feeds HTTP request messages, one byte per request, into the header checker
// and compares every verdict against a cycle-free model of the parser that
// runs on the accepted requests. Directed messages come first, then random
// well-formed and broken messages under several idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_http_request_header_checker;
    import hrhc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [63:0] VER_ONE_ONE    = "HTTP/1.1";
    localparam logic [63:0] VER_ONE_ZERO   = "HTTP/1.0";
    localparam logic [7:0]  CH_VT          = 8'h0B;
    localparam logic [7:0]  CH_FF          = 8'h0C;

    // Parser model plus the queue of verdicts still owed by the block.
    class verdict_board;
        phase_t      stage;
        verdict_t    held;
        bit          got_byte;
        bit [1:0]    tokens;
        bit          in_word;
        bit [3:0]    ver_idx;
        bit [1:0]    ver_alive;    // bit0 still HTTP/1.1, bit1 still HTTP/1.0
        bit [1:0]    line_len;
        cls_t        lead;
        bit          colon_after;
        bit          had_header;
        verdict_t    verdict_q[$];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void new_line();
            line_len    = 2'd0;
            lead        = CLS_OTHER;
            colon_after = 1'b0;
        endfunction

        function void restart();
            stage      = PH_REQUEST;
            held       = V_VALID;
            got_byte   = 1'b0;
            tokens     = 2'd0;
            in_word    = 1'b0;
            ver_idx    = 4'd0;
            ver_alive  = 2'b11;
            had_header = 1'b0;
            new_line();
        endfunction

        function void settle(verdict_t v);
            stage = PH_DONE;
            held  = v;
        endfunction

        // Queue a verdict behind the ones already owed.
        function void owe_verdict(verdict_t v);
            verdict_q.insert(verdict_q.size(), v);
        endfunction

        function bit whitespace(logic [7:0] b);
            return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT ||
                   b == CH_FF || b == CH_CR;
        endfunction

        function void close_version();
            if (ver_idx == POS_FULL && ver_alive != 2'b00) begin
                ver_idx = POS_ACCEPTED;
            end else begin
                settle(V_INVALID);
            end
        endfunction

        function void close_request_line();
            if (in_word && tokens == TOK_LAST && ver_idx != POS_ACCEPTED) begin
                close_version();
            end
            in_word = 1'b0;
            if (stage == PH_REQUEST) begin
                if (tokens == TOK_LAST && ver_idx == POS_ACCEPTED) begin
                    stage = PH_HEADER;
                    new_line();
                end else begin
                    settle(V_INVALID);
                end
            end
        endfunction

        function void take_request_byte(logic [7:0] b);
            int base;
            if (b == CH_LF) begin
                close_request_line();
            end else if (whitespace(b)) begin
                if (in_word) begin
                    in_word = 1'b0;
                    if (tokens == TOK_LAST && ver_idx != POS_ACCEPTED) begin
                        close_version();
                    end
                end
            end else begin
                if (!in_word) begin
                    in_word = 1'b1;
                    if (tokens != TOK_LAST) begin
                        tokens++;
                        if (tokens == TOK_LAST) begin
                            ver_idx   = 4'd0;
                            ver_alive = 2'b11;
                        end
                    end
                end
                // compare the third token against both versions at once
                if (tokens == TOK_LAST && ver_idx < POS_FULL) begin
                    base = 63 - 8 * int'(ver_idx);
                    if (b != VER_ONE_ONE[base -: 8]) begin
                        ver_alive[0] = 1'b0;
                    end
                    if (b != VER_ONE_ZERO[base -: 8]) begin
                        ver_alive[1] = 1'b0;
                    end
                    ver_idx++;
                end else if (tokens == TOK_LAST && ver_idx == POS_FULL) begin
                    ver_idx = POS_TOO_LONG;
                end
            end
        endfunction

        function void close_header_line();
            if (line_len == 2'd0 || (line_len == 2'd1 && lead == CLS_CR)) begin
                settle(V_VALID);
            end else if (lead == CLS_BLANK) begin
                if (!had_header) begin
                    settle(V_INVALID);
                end
            end else if (lead == CLS_COLON || !colon_after) begin
                settle(V_INVALID);
            end else begin
                had_header = 1'b1;
            end
            new_line();
        endfunction

        function void take_header_byte(logic [7:0] b);
            if (b == CH_LF) begin
                close_header_line();
            end else begin
                if (line_len == 2'd0) begin
                    case (b)
                        CH_SP, CH_TAB: lead = CLS_BLANK;
                        CH_COLON:      lead = CLS_COLON;
                        CH_CR:         lead = CLS_CR;
                        default:       lead = CLS_OTHER;
                    endcase
                end else if (b == CH_COLON) begin
                    colon_after = 1'b1;
                end
                if (line_len != LEN_SAT) begin
                    line_len++;
                end
            end
        endfunction

        function void note_request(logic [7:0] b, bit has_byte, bit at_end);
            if (has_byte) begin
                got_byte = 1'b1;
                if (stage == PH_REQUEST) begin
                    take_request_byte(b);
                end else if (stage == PH_HEADER) begin
                    take_header_byte(b);
                end
            end
            if (at_end) begin
                if (stage == PH_REQUEST) begin
                    if (got_byte) begin
                        close_request_line();
                    end else begin
                        settle(V_INCOMPLETE);
                    end
                end else if (stage == PH_HEADER && line_len != 2'd0) begin
                    // an open last line still gets judged
                    close_header_line();
                end
                owe_verdict(stage == PH_DONE ? held : V_INCOMPLETE);
                restart();
            end
        endfunction

        function void check_verdict(logic [7:0] got);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                $display("%0t ns: ERROR verdict with none pending: expected none, got %0d",
                         $time, got[1:0]);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (got[1:0] !== want) begin
                $display("%0t ns: ERROR verdict: expected %0d, got %0d",
                         $time, want, got[1:0]);
                errors++;
            end
            if (got[7:2] !== 6'd0) begin
                $display("%0t ns: ERROR verdict padding: expected 0, got 0x%0h",
                         $time, got[7:2]);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0] s_tuser  = 1'b0;    // [0] byte_valid
    logic       s_tlast  = 1'b0;    // end_of_message
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] verdict, [7:2] zero

    verdict_board board;
    logic [7:0]   byte_q[$];        // bytes of the message being built
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;
    int unsigned  items_sent    = 0;
    int unsigned  msgs_sent     = 0;
    int unsigned  idle_cycles   = 0;

    http_request_header_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Verdict side: check what left at this edge, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_verdict(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Drop the run if neither side moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: ERROR watchdog: no handshake for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("http_request_header_checker: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it
    // until the block takes it.
    task automatic send_request(input logic [7:0] b, input bit has_byte, input bit at_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has_byte;
        s_tlast  <= at_end;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        board.note_request(b, has_byte, at_end);
        if (has_byte || at_end) begin
            items_sent++;
        end
    endtask

    // Send byte_q as one message; end it on its last byte or on a bare end
    // mark, and slip in requests that carry neither now and then.
    task automatic send_message();
        bit bare_end;
        bare_end = (byte_q.size() == 0) || ($urandom_range(99) < 30);
        foreach (byte_q[i]) begin
            if ($urandom_range(99) < 4) begin
                send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_request(byte_q[i], 1'b1, !bare_end && i == byte_q.size() - 1);
        end
        if (bare_end) begin
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        msgs_sent++;
    endtask

    // Stop sending and hold until every verdict is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Append one byte to the message being built.
    function automatic void append_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_blank();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 5) begin
            return CH_SP;
        end else if (k == 5) begin
            return CH_TAB;
        end else if (k == 6) begin
            return CH_VT;
        end else if (k == 7) begin
            return CH_FF;
        end
        return CH_CR;
    endfunction

    // Mostly lowercase letters, sometimes any byte that is not whitespace.
    function automatic logic [7:0] pick_word_char();
        if ($urandom_range(99) < 80) begin
            return 8'($urandom_range(8'h7A, 8'h61));
        end
        return 8'($urandom_range(8'hFF, 8'h21));
    endfunction

    function automatic void add_word(input int unsigned lo, input int unsigned hi);
        repeat ($urandom_range(hi, lo)) append_byte(pick_word_char());
    endfunction

    // Third token: usually a good version, else one char off, cut short,
    // too long or with a lower-case first letter.
    function automatic void add_version();
        logic [63:0] ver;
        int unsigned len;
        int unsigned mut;
        ver = $urandom_range(1) ? VER_ONE_ONE : VER_ONE_ZERO;
        len = 8;
        mut = $urandom_range(9);
        if (mut == 0) begin
            ver[63 - 8 * $urandom_range(7) -: 8] = pick_word_char();
        end else if (mut == 1) begin
            len = $urandom_range(7, 1);
        end else if (mut == 3) begin
            ver[63 -: 8] = 8'h68;
        end
        for (int i = 0; i < len; i++) begin
            append_byte(ver[63 - 8 * i -: 8]);
        end
        if (mut == 2) begin
            add_word(1, 2);
        end
    endfunction

    function automatic void build_message();
        int unsigned tokens_wanted;
        int unsigned kind;
        byte_q.delete();
        // plain noise
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(12, 1)) append_byte(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(99) < 10) begin
            append_byte(pick_blank());
        end
        if ($urandom_range(99) < 12) begin
            tokens_wanted = $urandom_range(2);
        end else begin
            tokens_wanted = 3 + (($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0);
        end
        for (int t = 1; t <= tokens_wanted; t++) begin
            if (t > 1) begin
                append_byte(pick_blank());
                if ($urandom_range(99) < 20) begin
                    append_byte(pick_blank());
                end
            end
            if (t == 3) begin
                add_version();
            end else begin
                add_word(1, 5);
            end
        end
        if ($urandom_range(99) < 15) begin
            append_byte(pick_blank());
        end
        if ($urandom_range(99) < 60) begin
            append_byte(CH_CR);
        end
        // leave the request line open now and then
        if ($urandom_range(99) < 5) begin
            return;
        end
        append_byte(CH_LF);
        repeat ($urandom_range(2)) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                add_word(1, 5);
                append_byte(CH_COLON);
                if ($urandom_range(1)) begin
                    append_byte(CH_SP);
                end
                add_word(0, 5);
            end else if (kind < 80) begin
                append_byte($urandom_range(1) ? CH_SP : CH_TAB);
                add_word(1, 4);
            end else if (kind < 90) begin
                add_word(1, 6);
            end else begin
                append_byte(CH_COLON);
                add_word(0, 4);
            end
            if ($urandom_range(99) < 80) begin
                append_byte(CH_CR);
            end
            append_byte(CH_LF);
        end
        // how the header block ends, if it does
        kind = $urandom_range(99);
        if (kind < 45) begin
            append_byte(CH_CR);
            append_byte(CH_LF);
        end else if (kind < 65) begin
            append_byte(CH_LF);
        end else if (kind < 72) begin
            append_byte(CH_CR);
        end else if (kind < 78) begin
            append_byte(CH_CR);
            append_byte(CH_CR);
            append_byte(CH_LF);
        end else if (kind < 88) begin
            add_word(1, 3);
            if ($urandom_range(1)) begin
                append_byte(CH_COLON);
                add_word(0, 3);
            end
        end
        // trailing bytes, ignored once a verdict is settled
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(4, 1)) append_byte(8'($urandom_range(255)));
        end
    endfunction

    initial begin
        string req_line;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty message, an ignored request then a single 0xFF
        // byte, and a minimal valid request.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1);
        req_line = "a b HTTP/1.1";
        byte_q.delete();
        for (int i = 0; i < req_line.len(); i++) begin
            append_byte(req_line[i]);
        end
        append_byte(CH_CR);
        append_byte(CH_LF);
        append_byte(CH_CR);
        append_byte(CH_LF);
        send_message();
        drain();

        // Random messages under four idle/stall mixes; drain between them.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            while (items_sent < 125 * (p + 1) + 20 || msgs_sent < 10 * (p + 1) + 3) begin
                build_message();
                send_message();
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("http_request_header_checker: match");
        end else begin
            $display("http_request_header_checker: mismatch");
        end
        $finish;
    end
endmodule
